[hw/rtl/rrps_pkg.sv]
// Shared codes, field widths and defaults for the round-robin priority scheduler.
package rrps_pkg;

    localparam int DEFAULT_SLOT_COUNT = 64;

    localparam int FUNC_W   = 1;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int PRIO_W   = 8;
    localparam int OUTC_W   = 2;
    localparam int COUNT_W  = 32;
    localparam int ENTRY_W  = STATUS_W + PRIO_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_PRIORITY = 1'd1;

    localparam logic [PRIO_W-1:0] LOWEST_PRIORITY_RESET = 8'd255;

    localparam logic [FUNC_W-1:0] FUNC_WRITE    = 1'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 1'd1;

    localparam logic [STATUS_W-1:0] ST_FREE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DYING    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RUNNABLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd3;

    localparam logic OUT_MODE_RR   = 1'b0;

    localparam logic [OUTC_W-1:0] OUTC_RUN     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_RERUN   = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_HALT    = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_NO_LIVE = 2'd3;

endpackage

[hw/rtl/rrps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/round_robin_priority_scheduler.sv]
// Top level of the round-robin / priority task scheduler with its slot table in RAM.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer. A write item
// (func 0) stores status and priority for one slot and gives no result; an index
// beyond the table is dropped. A schedule item (func 1) counts the call and reads the
// whole slot table once, one slot per cycle through the RAM read port, starting after
// the current slot (at slot 0 when there is none). It picks the first runnable slot
// (round robin) or the lowest priority runnable slot below the limit (priority mode),
// and finds in the same pass whether any task is still live. The table sweep through
// the single read port sets how long a schedule item takes from transfer to result.
// The result goes out on o_out_valid / i_out_stall from an output register. A new item
// is taken while a result waits, but a finished scan holds until that register frees.
// After reset the block clears every slot of the table and stalls input meanwhile;
// configuration writes are taken in any state of the block, the clear included.
module round_robin_priority_scheduler
    import rrps_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [INDEX_W-1:0]    i_slot_index,
    input  logic [STATUS_W-1:0]   i_slot_status,
    input  logic [PRIO_W-1:0]     i_slot_priority,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUTC_W-1:0]     o_outcome,
    output logic [INDEX_W-1:0]    o_chosen_slot,
    output logic [COUNT_W-1:0]    o_call_count
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W:0]   SCAN_LEN  = (SLOT_W + 1)'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;

    logic                  r_mode;
    logic [PRIO_W-1:0]     r_lowest;

    logic                  r_cur_valid;
    logic [SLOT_W-1:0]     r_cur_slot;
    logic [STATUS_W-1:0]   r_cur_status;
    logic [PRIO_W-1:0]     r_cur_prio;
    logic [COUNT_W-1:0]    r_calls;

    logic [SLOT_W-1:0]     r_addr;
    logic [SLOT_W:0]       r_issue;
    logic                  r_rd_v;
    logic [SLOT_W-1:0]     r_rd_slot;
    logic                  r_found;
    logic                  r_live;
    logic [SLOT_W-1:0]     r_pick;
    logic [PRIO_W-1:0]     r_pick_prio;
    logic [PRIO_W:0]       r_limit;

    logic                  r_out_valid;
    logic [OUTC_W-1:0]     r_outcome;
    logic [INDEX_W-1:0]    r_chosen;
    logic [COUNT_W-1:0]    r_count;

    logic                  in_xfer;
    logic                  wr_in_range;
    logic [SLOT_W-1:0]     wr_slot;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [STATUS_W-1:0]   rd_status;
    logic [PRIO_W-1:0]     rd_prio;
    logic                  issue_done;
    logic                  out_free;
    logic                  res_load;
    logic [SLOT_W-1:0]     start_slot;
    logic [SLOT_W-1:0]     next_addr;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_xfer      = i_in_valid && (r_state == S_IDLE);
    assign wr_in_range  = ({{(COUNT_W - INDEX_W){1'b0}}, i_slot_index} < COUNT_W'(SLOT_COUNT));
    assign wr_slot      = SLOT_W'(i_slot_index);
    assign rd_status    = ram_rdata[ENTRY_W-1:PRIO_W];
    assign rd_prio      = ram_rdata[PRIO_W-1:0];
    assign issue_done   = (r_issue == SCAN_LEN);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign res_load     = (r_state == S_SCAN) && issue_done && !r_rd_v && out_free;
    assign next_addr    = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
    assign start_slot   = !r_cur_valid ? '0 :
                          (r_cur_slot == LAST_SLOT) ? '0 : r_cur_slot + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_slot;
        ram_wdata = {i_slot_status, i_slot_priority};
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = {ST_FREE, {PRIO_W{1'b0}}};
        end else if (in_xfer && i_func == FUNC_WRITE && wr_in_range) begin
            ram_we = 1'b1;
        end
    end

    rrps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_mode       <= OUT_MODE_RR;
            r_lowest     <= LOWEST_PRIORITY_RESET;
            r_cur_valid  <= 1'b0;
            r_cur_slot   <= '0;
            r_cur_status <= ST_FREE;
            r_cur_prio   <= '0;
            r_calls      <= '0;
            r_addr       <= '0;
            r_issue      <= '0;
            r_rd_v       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCHED_MODE:      r_mode   <= i_cfg_data[0];
                    CFG_LOWEST_PRIORITY: r_lowest <= i_cfg_data[PRIO_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !res_load) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v    <= (r_state == S_SCAN) && !issue_done;
            r_rd_slot <= r_addr;

            case (r_state)
                S_CLEAR: begin
                    r_addr <= next_addr;
                    if (r_addr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_func == FUNC_WRITE) begin
                            // Keep the current slot's copy in step with the table.
                            if (wr_in_range && wr_slot == r_cur_slot) begin
                                r_cur_status <= i_slot_status;
                                r_cur_prio   <= i_slot_priority;
                            end
                        end else begin
                            r_calls   <= r_calls + 1'b1;
                            r_addr    <= start_slot;
                            r_issue   <= '0;
                            r_found   <= 1'b0;
                            r_live    <= 1'b0;
                            r_limit   <= r_cur_valid ? {1'b0, r_cur_prio} + 1'b1
                                                     : {1'b0, r_lowest};
                            r_state   <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (!issue_done) begin
                        r_addr  <= next_addr;
                        r_issue <= r_issue + 1'b1;
                    end
                    if (r_rd_v) begin
                        if (rd_status == ST_RUNNABLE || rd_status == ST_RUNNING ||
                            rd_status == ST_DYING) begin
                            r_live <= 1'b1;
                        end
                        if (rd_status == ST_RUNNABLE) begin
                            if (r_mode == OUT_MODE_RR) begin
                                if (!r_found) begin
                                    r_found     <= 1'b1;
                                    r_pick      <= r_rd_slot;
                                    r_pick_prio <= rd_prio;
                                end
                            end else if ({1'b0, rd_prio} < r_limit) begin
                                r_found     <= 1'b1;
                                r_pick      <= r_rd_slot;
                                r_pick_prio <= rd_prio;
                                r_limit     <= {1'b0, rd_prio};
                            end
                        end
                    end
                    if (res_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_found) begin
                            r_outcome    <= OUTC_RUN;
                            r_chosen     <= INDEX_W'(r_pick);
                            r_cur_valid  <= 1'b1;
                            r_cur_slot   <= r_pick;
                            r_cur_status <= ST_RUNNABLE;
                            r_cur_prio   <= r_pick_prio;
                        end else if (r_cur_valid && r_cur_status == ST_RUNNING) begin
                            r_outcome <= OUTC_RERUN;
                            r_chosen  <= INDEX_W'(r_cur_slot);
                        end else if (r_live) begin
                            r_outcome   <= OUTC_HALT;
                            r_chosen    <= '0;
                            r_cur_valid <= 1'b0;
                            r_cur_slot  <= '0;
                        end else begin
                            r_outcome <= OUTC_NO_LIVE;
                            r_chosen  <= '0;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The call count shown is the one taken at this item's transfer; no other
    // schedule item can start before its result is loaded.
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_count <= r_calls;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_chosen_slot = r_chosen;
    assign o_call_count  = r_count;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the round-robin priority scheduler with a predicting scoreboard.
module tb;
    import rrps_pkg::*;

    localparam int SLOTS = DEFAULT_SLOT_COUNT;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd4;

    typedef struct packed {
        logic [OUTC_W-1:0]  outcome;
        logic [INDEX_W-1:0] slot;
        logic [COUNT_W-1:0] count;
    } t_sched_result;

    // Mirrors the slot table, the current slot and the request counter, and holds
    // the schedule results still owed by the block.
    class t_sched_tracker;
        logic [STATUS_W-1:0] status_tab [SLOTS];
        logic [PRIO_W-1:0]   prio_tab [SLOTS];
        bit                  cur_valid;
        logic [INDEX_W-1:0]  cur_slot;
        logic [COUNT_W-1:0]  req_count;
        logic                mode;
        logic [PRIO_W-1:0]   lowest;
        t_sched_result       awaited [$];
        int                  mismatches;

        function new();
            foreach (status_tab[k]) begin
                status_tab[k] = ST_FREE;
                prio_tab[k] = '0;
            end
            cur_valid = 1'b0;
            cur_slot = '0;
            req_count = '0;
            mode = OUT_MODE_RR;
            lowest = LOWEST_PRIORITY_RESET;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SCHED_MODE) begin
                mode = data[0];
            end else if (idx == CFG_LOWEST_PRIORITY) begin
                lowest = data;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function t_sched_result schedule();
            int unsigned        scan;
            int unsigned        bound;
            bit                 hit;
            bit                 live;
            logic [INDEX_W-1:0] pick;
            t_sched_result      r;
            hit = 1'b0;
            live = 1'b0;
            pick = '0;
            req_count = req_count + 1'b1;
            if (cur_valid) begin
                scan = int'(cur_slot) + 1;
                bound = int'(prio_tab[cur_slot]) + 1;
            end else begin
                scan = 0;
                bound = int'(lowest);
            end
            if (scan >= SLOTS) begin
                scan = 0;
            end
            for (int k = 0; k < SLOTS; k++) begin
                if (status_tab[scan] == ST_RUNNABLE) begin
                    if (mode == OUT_MODE_RR) begin
                        if (!hit) begin
                            hit = 1'b1;
                            pick = INDEX_W'(scan);
                        end
                    end else if (prio_tab[scan] < bound) begin
                        // Strictly below the running bound, so the first slot met wins ties.
                        hit = 1'b1;
                        pick = INDEX_W'(scan);
                        bound = int'(prio_tab[scan]);
                    end
                end
                if (status_tab[scan] == ST_RUNNABLE || status_tab[scan] == ST_RUNNING ||
                    status_tab[scan] == ST_DYING) begin
                    live = 1'b1;
                end
                scan = (scan + 1) % SLOTS;
            end
            if (hit) begin
                r.outcome = OUTC_RUN;
                cur_valid = 1'b1;
                cur_slot = pick;
            end else if (cur_valid && status_tab[cur_slot] == ST_RUNNING) begin
                r.outcome = OUTC_RERUN;
                pick = cur_slot;
            end else if (live) begin
                r.outcome = OUTC_HALT;
                pick = '0;
                cur_valid = 1'b0;
                cur_slot = '0;
            end else begin
                r.outcome = OUTC_NO_LIVE;
                pick = '0;
            end
            r.slot = pick;
            r.count = req_count;
            return r;
        endfunction

        function void note_item(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                                logic [STATUS_W-1:0] st, logic [PRIO_W-1:0] pr);
            if (func == FUNC_WRITE) begin
                if (int'(idx) < SLOTS) begin
                    status_tab[idx] = st;
                    prio_tab[idx] = pr;
                end
            end else begin
                awaited.push_back(schedule());
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", what);
            end
        endfunction

        function void check_result(logic [OUTC_W-1:0] outc, logic [INDEX_W-1:0] slot,
                                   logic [COUNT_W-1:0] count);
            t_sched_result want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected schedule result: outcome %0d slot %0d count %0d",
                               outc, slot, count));
                return;
            end
            want = awaited.pop_front();
            if (outc !== want.outcome || slot !== want.slot || count !== want.count) begin
                flag($sformatf({"schedule result mismatch: expected outcome %0d slot %0d",
                                " count %0d, got outcome %0d slot %0d count %0d"},
                               want.outcome, want.slot, want.count, outc, slot, count));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [FUNC_W-1:0]     i_func;
    logic [INDEX_W-1:0]    i_slot_index;
    logic [STATUS_W-1:0]   i_slot_status;
    logic [PRIO_W-1:0]     i_slot_priority;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [OUTC_W-1:0]     o_outcome;
    logic [INDEX_W-1:0]    o_chosen_slot;
    logic [COUNT_W-1:0]    o_call_count;

    t_sched_tracker tracker = new();
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left = 0;

    round_robin_priority_scheduler #(.SLOT_COUNT(SLOTS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_slot_index   (i_slot_index),
        .i_slot_status  (i_slot_status),
        .i_slot_priority(i_slot_priority),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_outcome      (o_outcome),
        .o_chosen_slot  (o_chosen_slot),
        .o_call_count   (o_call_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, or a long hold-off while hold_left runs down.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_outcome, o_chosen_slot, o_call_count);
        end
    end

    // Returns at the rising edge of the transfer; the caller's next drive is a falling edge.
    task automatic offer_item(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                              input logic [STATUS_W-1:0] st, input logic [PRIO_W-1:0] pr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_slot_index <= idx;
        i_slot_status <= st;
        i_slot_priority <= pr;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(func, idx, st, pr);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(idx, data);
    endtask

    // Write items give no result, so allow a full scan time after the last result.
    task automatic settle();
        drop_valid();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
    endtask

    function automatic logic [STATUS_W-1:0] pick_status();
        int r;
        r = $urandom_range(99);
        if (r < 30) return ST_RUNNABLE;
        if (r < 45) return ST_RUNNING;
        if (r < 60) return ST_FREE;
        if (r < 70) return ST_DYING;
        if (r < 80) return ST_BLOCKED;
        return STATUS_W'($urandom_range(5, 7));
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0: return PRIO_W'($urandom);
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            2: return PRIO_W'($urandom_range(100, 103));
            default: return PRIO_W'($urandom_range(15));
        endcase
    endfunction

    // Mostly task-like traffic on a small window of slots, often marking the slot just
    // dispatched as running, with some writes anywhere in the table.
    task automatic offer_random_item(input int base);
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            offer_item(FUNC_SCHEDULE, INDEX_W'($urandom), STATUS_W'($urandom), PRIO_W'($urandom));
        end else if (r < 50 && tracker.cur_valid) begin
            offer_item(FUNC_WRITE, tracker.cur_slot,
                       ($urandom_range(3) == 0) ? ST_RUNNABLE : ST_RUNNING, pick_prio());
        end else if (r < 90) begin
            offer_item(FUNC_WRITE, INDEX_W'(base + $urandom_range(7)), pick_status(), pick_prio());
        end else begin
            offer_item(FUNC_WRITE, INDEX_W'($urandom), STATUS_W'($urandom), PRIO_W'($urandom));
        end
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
                             input logic mode, input logic [PRIO_W-1:0] lowest,
                             input bit with_hold, input bit with_pause);
        int base;
        settle();
        write_reg(CFG_SCHED_MODE, {7'($urandom), mode});
        write_reg(CFG_LOWEST_PRIORITY, lowest);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        // Start from a table with no live task so that the quiet outcomes stay reachable.
        for (int k = 0; k < SLOTS; k++) begin
            if (tracker.status_tab[k] != ST_FREE) begin
                offer_item(FUNC_WRITE, INDEX_W'(k), ST_FREE, PRIO_W'($urandom));
            end
        end
        if (with_hold) begin
            hold_left = 500;
        end
        base = $urandom_range(SLOTS - 1);
        for (int n = 0; n < n_items; n++) begin
            if (with_pause && n == n_items / 2) begin
                drop_valid();
                while (tracker.pending() != 0) @(posedge i_clk);
            end
            offer_random_item(base);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func = '0;
        i_slot_index = '0;
        i_slot_status = '0;
        i_slot_priority = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_SCHED_MODE, 8'h00);
        write_reg(CFG_LOWEST_PRIORITY, LOWEST_PRIORITY_RESET);

        // Round robin: empty table, last slot, scan start wrapping past the end,
        // rerun, halt on a dying task, unknown status codes, rotation.
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd63, ST_RUNNABLE, 8'd255);
        offer_item(FUNC_WRITE, 6'd0, 3'd7, 8'd0);
        offer_item(FUNC_SCHEDULE, 6'd63, 3'd7, 8'd255);
        offer_item(FUNC_WRITE, 6'd63, ST_RUNNING, 8'd255);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd63, ST_DYING, 8'd0);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd63, ST_FREE, 8'd128);
        offer_item(FUNC_WRITE, 6'd5, 3'd5, 8'd1);
        offer_item(FUNC_WRITE, 6'd7, ST_BLOCKED, 8'd2);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd10, ST_RUNNABLE, 8'd50);
        offer_item(FUNC_WRITE, 6'd20, ST_RUNNABLE, 8'd50);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);

        // Priority mode: lowest value wins, ties go to the first slot met, the
        // running slot's priority bounds the choice.
        settle();
        write_reg(CFG_SCHED_MODE, 8'h01);
        write_reg(CFG_LOWEST_PRIORITY, 8'd200);
        offer_item(FUNC_WRITE, 6'd40, ST_RUNNABLE, 8'd7);
        offer_item(FUNC_WRITE, 6'd41, ST_RUNNABLE, 8'd7);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd41, ST_RUNNING, 8'd0);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);
        offer_item(FUNC_WRITE, 6'd41, ST_DYING, 8'd255);
        offer_item(FUNC_SCHEDULE, 6'd0, 3'd0, 8'd0);

        run_phase(100, 0, 0, 1'b0, 8'd255, 1'b0, 1'b0);
        run_phase(100, 61, 0, 1'b1, 8'd255, 1'b0, 1'b0);
        run_phase(100, 0, 61, 1'b1, 8'd0, 1'b0, 1'b0);
        run_phase(100, 36, 36, 1'b1, PRIO_W'($urandom_range(1, 254)), 1'b1, 1'b0);
        run_phase(100, 36, 36, 1'b0, PRIO_W'($urandom), 1'b0, 1'b1);

        drop_valid();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
